// ===== design/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, character codes, stack symbols and error codes for the
// bracket balance checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 256;
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    localparam logic [LVL_W-1:0] LVL_ZERO = '0;
    localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);
    localparam logic [LVL_W-1:0] LVL_TWO  = LVL_W'(2);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);

    // line counter
    localparam logic [15:0] LINE_FIRST = 16'd1;
    localparam logic [15:0] LINE_MAX   = 16'hFFFF;

    // character codes
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_APOS     = 8'h27;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_LSQUARE  = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RSQUARE  = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    // stack symbols
    typedef enum logic [2:0] {
        SYM_NONE   = 3'd0,
        SYM_BRACE  = 3'd1,
        SYM_PAREN  = 3'd2,
        SYM_SQUARE = 3'd3,
        SYM_APOS   = 3'd4,
        SYM_QUOTE  = 3'd5,
        SYM_BSLASH = 3'd6
    } sym_t;

    // sticky error codes
    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_UNCLOSED     = 4'd1,
        ERR_MISS_BRACE   = 4'd2,
        ERR_MISS_PAREN   = 4'd3,
        ERR_MISS_SQUARE  = 4'd4,
        ERR_WRONG_BRACE  = 4'd5,
        ERR_WRONG_PAREN  = 4'd6,
        ERR_WRONG_SQUARE = 4'd7,
        ERR_OVERFLOW     = 4'd8
    } err_t;

    // expected closer codes
    typedef enum logic [1:0] {
        CLOSE_NONE   = 2'd0,
        CLOSE_BRACE  = 2'd1,
        CLOSE_PAREN  = 2'd2,
        CLOSE_SQUARE = 2'd3
    } close_t;

    // input and result words
    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [3:0]  fault_code;
        logic [15:0] line_number;
        logic [1:0]  expected_close;
        logic        halted;
    } out_t;

    // stack request from the scanner
    typedef struct packed {
        logic push;
        logic pop;
        sym_t sym;
    } stack_op_t;

    // stack status toward the scanner
    typedef struct packed {
        logic empty;
        logic full;
        sym_t top;
        sym_t after;
    } stack_stat_t;

    // closer expected by a stack symbol
    function automatic close_t close_of(input sym_t s);
        close_t c;
        case (s)
            SYM_BRACE:  c = CLOSE_BRACE;
            SYM_PAREN:  c = CLOSE_PAREN;
            SYM_SQUARE: c = CLOSE_SQUARE;
            default:    c = CLOSE_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/bbc_stack.sv =====
// ----------------------------------------------------------------------------
// bbc_stack
// Symbol stack: top entry in a register, the entries below it in a memory.
// The entry under the top is prefetched each cycle so a pop is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_stack (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bbc_pkg::stack_op_t  op,
    output bbc_pkg::stack_stat_t     stat
);

    logic [bbc_pkg::LVL_W-1:0] level_reg;
    logic [bbc_pkg::LVL_W-1:0] level_next;
    bbc_pkg::sym_t             top_reg;
    bbc_pkg::sym_t             top_next;
    bbc_pkg::sym_t             below_reg;
    logic [bbc_pkg::LVL_W-1:0] wr_lvl;
    logic [bbc_pkg::LVL_W-1:0] rd_lvl;
    logic [bbc_pkg::IDX_W-1:0] wr_addr;
    logic [bbc_pkg::IDX_W-1:0] rd_addr;
    logic                      wr_en;

    bbc_pkg::sym_t mem [bbc_pkg::STACK_DEPTH];

    // next level and top
    always_comb
    begin
        level_next = level_reg;
        top_next   = top_reg;
        if (op.push)
        begin
            level_next = level_reg + bbc_pkg::LVL_ONE;
            top_next   = op.sym;
        end
        else if (op.pop)
        begin
            level_next = level_reg - bbc_pkg::LVL_ONE;
            top_next   = below_reg;
        end
    end

    // old top spills into memory on push, entry under new top is read back
    always_comb
    begin
        wr_lvl  = level_reg - bbc_pkg::LVL_ONE;
        rd_lvl  = level_next - bbc_pkg::LVL_TWO;
        wr_addr = wr_lvl[bbc_pkg::IDX_W-1:0];
        rd_addr = rd_lvl[bbc_pkg::IDX_W-1:0];
        wr_en   = op.push && (level_reg != bbc_pkg::LVL_ZERO);
    end

    // stack memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= top_reg;
        end
        if (op.push)
        begin
            below_reg <= top_reg;
        end
        else
        begin
            below_reg <= mem[rd_addr];
        end
    end

    // level and top registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= bbc_pkg::LVL_ZERO;
            top_reg   <= bbc_pkg::SYM_NONE;
        end
        else
        begin
            level_reg <= level_next;
            top_reg   <= top_next;
        end
    end

    // status toward the scanner
    always_comb
    begin
        stat.empty = (level_reg == bbc_pkg::LVL_ZERO);
        stat.full  = (level_reg == bbc_pkg::LVL_FULL);
        stat.top   = stat.empty ? bbc_pkg::SYM_NONE : top_reg;
        if (op.push)
        begin
            stat.after = op.sym;
        end
        else if (op.pop)
        begin
            stat.after = (level_reg == bbc_pkg::LVL_ONE) ? bbc_pkg::SYM_NONE : below_reg;
        end
        else
        begin
            stat.after = stat.top;
        end
    end

endmodule

`default_nettype wire

// ===== design/bbc_scan.sv =====
// ----------------------------------------------------------------------------
// bbc_scan
// Per-byte scanner: comment and quote tracking, bracket matching, line
// counting and the sticky error. Builds the result word for each step.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_scan (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire bbc_pkg::in_t          item,
    input  wire bbc_pkg::stack_stat_t  stat,
    output bbc_pkg::stack_op_t         op,
    output bbc_pkg::out_t              result
);

    logic          in_block_reg;
    logic          in_block_next;
    logic          star_reg;
    logic          star_next;
    logic          slash_reg;
    logic          slash_next;
    logic          skip_reg;
    logic          skip_next;
    logic [15:0]   line_reg;
    logic [15:0]   line_next;
    bbc_pkg::err_t err_reg;
    bbc_pkg::err_t err_next;
    logic          push_req;
    logic          pop_req;
    bbc_pkg::sym_t push_sym;
    logic          is_mark;
    bbc_pkg::sym_t mark_sym;
    logic [7:0]    c;

    assign c = item.char_byte;

    // quote marks and backslash
    always_comb
    begin
        case (c)
            bbc_pkg::CH_APOS:
            begin
                is_mark  = 1'b1;
                mark_sym = bbc_pkg::SYM_APOS;
            end
            bbc_pkg::CH_QUOTE:
            begin
                is_mark  = 1'b1;
                mark_sym = bbc_pkg::SYM_QUOTE;
            end
            bbc_pkg::CH_BSLASH:
            begin
                is_mark  = 1'b1;
                mark_sym = bbc_pkg::SYM_BSLASH;
            end
            default:
            begin
                is_mark  = 1'b0;
                mark_sym = bbc_pkg::SYM_NONE;
            end
        endcase
    end

    // next state for one byte
    always_comb
    begin
        push_req      = 1'b0;
        pop_req       = 1'b0;
        push_sym      = bbc_pkg::SYM_NONE;
        in_block_next = in_block_reg;
        star_next     = star_reg;
        slash_next    = slash_reg;
        skip_next     = skip_reg;
        line_next     = line_reg;
        err_next      = err_reg;
        if (step && (err_reg == bbc_pkg::ERR_NONE))
        begin
            if (item.end_of_text)
            begin
                if (!stat.empty)
                begin
                    err_next = bbc_pkg::ERR_UNCLOSED;
                end
            end
            else
            begin
                if (in_block_reg)
                begin
                    // block comment: look for star then slash
                    if (star_reg && (c == bbc_pkg::CH_SLASH))
                    begin
                        in_block_next = 1'b0;
                        star_next     = 1'b0;
                    end
                    else
                    begin
                        star_next = (c == bbc_pkg::CH_STAR);
                    end
                end
                else if (!skip_reg)
                begin
                    slash_next = 1'b0;
                    if (is_mark)
                    begin
                        if ((stat.top == mark_sym) || (stat.top == bbc_pkg::SYM_BSLASH))
                        begin
                            pop_req = 1'b1;
                        end
                        else
                        begin
                            push_req = 1'b1;
                            push_sym = mark_sym;
                        end
                    end
                    else if (stat.top == bbc_pkg::SYM_BSLASH)
                    begin
                        // escaped byte
                        pop_req = 1'b1;
                    end
                    else if ((stat.top != bbc_pkg::SYM_APOS) &&
                             (stat.top != bbc_pkg::SYM_QUOTE))
                    begin
                        case (c)
                            bbc_pkg::CH_SLASH:
                            begin
                                if (slash_reg)
                                begin
                                    skip_next = 1'b1;
                                end
                                else
                                begin
                                    slash_next = 1'b1;
                                end
                            end
                            bbc_pkg::CH_STAR:
                            begin
                                if (slash_reg)
                                begin
                                    in_block_next = 1'b1;
                                    star_next     = 1'b0;
                                end
                            end
                            bbc_pkg::CH_LBRACE:
                            begin
                                push_req = 1'b1;
                                push_sym = bbc_pkg::SYM_BRACE;
                            end
                            bbc_pkg::CH_LPAREN:
                            begin
                                push_req = 1'b1;
                                push_sym = bbc_pkg::SYM_PAREN;
                            end
                            bbc_pkg::CH_LSQUARE:
                            begin
                                push_req = 1'b1;
                                push_sym = bbc_pkg::SYM_SQUARE;
                            end
                            bbc_pkg::CH_RBRACE:
                            begin
                                if (stat.top == bbc_pkg::SYM_BRACE)
                                begin
                                    pop_req = 1'b1;
                                end
                                else if (stat.empty)
                                begin
                                    err_next = bbc_pkg::ERR_MISS_BRACE;
                                end
                                else
                                begin
                                    err_next = bbc_pkg::ERR_WRONG_BRACE;
                                end
                            end
                            bbc_pkg::CH_RPAREN:
                            begin
                                if (stat.top == bbc_pkg::SYM_PAREN)
                                begin
                                    pop_req = 1'b1;
                                end
                                else if (stat.empty)
                                begin
                                    err_next = bbc_pkg::ERR_MISS_PAREN;
                                end
                                else
                                begin
                                    err_next = bbc_pkg::ERR_WRONG_PAREN;
                                end
                            end
                            bbc_pkg::CH_RSQUARE:
                            begin
                                if (stat.top == bbc_pkg::SYM_SQUARE)
                                begin
                                    pop_req = 1'b1;
                                end
                                else if (stat.empty)
                                begin
                                    err_next = bbc_pkg::ERR_MISS_SQUARE;
                                end
                                else
                                begin
                                    err_next = bbc_pkg::ERR_WRONG_SQUARE;
                                end
                            end
                            default:
                            begin
                                push_req = 1'b0;
                            end
                        endcase
                    end
                end
                // push onto a full stack
                if (push_req && stat.full)
                begin
                    err_next = bbc_pkg::ERR_OVERFLOW;
                end
                // newline ends a line comment and counts
                if ((err_next == bbc_pkg::ERR_NONE) && (c == bbc_pkg::CH_LF))
                begin
                    skip_next = 1'b0;
                    if (line_reg != bbc_pkg::LINE_MAX)
                    begin
                        line_next = line_reg + 16'd1;
                    end
                end
            end
        end
    end

    // stack request
    always_comb
    begin
        op.push = push_req && !stat.full;
        op.pop  = pop_req;
        op.sym  = push_sym;
    end

    // result word after this byte
    always_comb
    begin
        result.fault_code     = err_next;
        result.line_number    = line_next;
        result.expected_close = bbc_pkg::close_of(stat.after);
        result.halted         = (err_next != bbc_pkg::ERR_NONE);
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_block_reg <= 1'b0;
            star_reg     <= 1'b0;
            slash_reg    <= 1'b0;
            skip_reg     <= 1'b0;
            line_reg     <= bbc_pkg::LINE_FIRST;
            err_reg      <= bbc_pkg::ERR_NONE;
        end
        else
        begin
            in_block_reg <= in_block_next;
            star_reg     <= star_next;
            slash_reg    <= slash_next;
            skip_reg     <= skip_next;
            line_reg     <= line_next;
            err_reg      <= err_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/bracket_balance_checker_unit.sv =====
// Path: a result becomes valid once its accepted text word has passed the
// input register and then the result register.
// Throughput: one text word per cycle while results are taken; the stack top
// is in a register and the entry beneath it is prefetched from memory each cycle.
// Reset: stack empty, flags clear, line count 1, no error; stack memory is
// not cleared and words are accepted right after reset.
// ----------------------------------------------------------------------------
// bracket_balance_checker_unit
// Streams source text bytes and checks bracket balance, skipping comments
// and quoted text; reports the first error, line count and expected closer.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_balance_checker_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          text_valid,
    output logic               text_ready,
    input  wire bbc_pkg::in_t  text_word,
    output logic               result_valid,
    input  wire logic          result_ready,
    output bbc_pkg::out_t      result_word
);

    logic                 stage_valid_reg;
    logic                 stage_valid_next;
    bbc_pkg::in_t         stage_word_reg;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    bbc_pkg::out_t        result_word_reg;
    logic                 advance;
    logic                 text_accept;
    bbc_pkg::stack_op_t   op;
    bbc_pkg::stack_stat_t stat;
    bbc_pkg::out_t        result;

    // handshake control
    always_comb
    begin
        advance           = stage_valid_reg && (!result_valid_reg || result_ready);
        text_ready        = !stage_valid_reg || advance;
        text_accept       = text_valid && text_ready;
        stage_valid_next  = text_accept ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);
        result_valid_next = advance ? 1'b1 : (result_ready ? 1'b0 : result_valid_reg);
    end

    // scanner
    bbc_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (stage_word_reg),
        .stat   (stat),
        .op     (op),
        .result (result)
    );

    // symbol stack
    bbc_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .stat  (stat)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // input and result words
    always_ff @(posedge clk)
    begin
        if (text_accept)
        begin
            stage_word_reg <= text_word;
        end
        if (advance)
        begin
            result_word_reg <= result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams source text words into the bracket balance checker and compares
// every status word against a scanner predictor kept in step with the block.
// Text is mostly error-free random source with brackets, quotes, escapes and
// comments. It adds a full stack nest. It ends with one randomly chosen
// error, after which the block must stay halted.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // predictor copies: one follows accepted words, one plans the stimulus
    localparam int CHK  = 0;
    localparam int PLAN = 1;

    localparam logic [7:0] OPEN_CH  [3] = '{bbc_pkg::CH_LBRACE, bbc_pkg::CH_LPAREN,
                                            bbc_pkg::CH_LSQUARE};
    localparam logic [7:0] CLOSE_CH [3] = '{bbc_pkg::CH_RBRACE, bbc_pkg::CH_RPAREN,
                                            bbc_pkg::CH_RSQUARE};

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          text_valid   = 1'b0;
    logic          text_ready;
    bbc_pkg::in_t  text_word    = '0;
    logic          result_valid;
    logic          result_ready = 1'b0;
    bbc_pkg::out_t result_word;

    bbc_pkg::in_t  source_q [$];
    bbc_pkg::out_t report_q [$];

    // scanner state, one set per copy
    bbc_pkg::sym_t stk_sym    [2][bbc_pkg::STACK_DEPTH];
    int unsigned   stk_lvl    [2];
    bit            in_cmt     [2];
    bit            cmt_star   [2];
    bit            slash_wait [2];
    bit            line_cmt   [2];
    logic [15:0]   line_cnt   [2];
    bbc_pkg::err_t first_err  [2];

    int            fail_count = 0;
    int            tx_wait    = 0;
    int            tx_calm    = 0;
    int            rx_wait    = 0;
    int            rx_calm    = 0;
    int            rx_left;
    bbc_pkg::out_t want;

    bracket_balance_checker_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_word    (text_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_scan(input int k);
        stk_lvl[k]    = 0;
        in_cmt[k]     = 1'b0;
        cmt_star[k]   = 1'b0;
        slash_wait[k] = 1'b0;
        line_cmt[k]   = 1'b0;
        line_cnt[k]   = bbc_pkg::LINE_FIRST;
        first_err[k]  = bbc_pkg::ERR_NONE;
    endfunction

    function automatic bbc_pkg::sym_t top_sym(input int k);
        if (stk_lvl[k] == 0)
            return bbc_pkg::SYM_NONE;
        return stk_sym[k][stk_lvl[k] - 1];
    endfunction

    function automatic void push_sym(input int k, input bbc_pkg::sym_t s);
        if (stk_lvl[k] >= bbc_pkg::STACK_DEPTH)
            first_err[k] = bbc_pkg::ERR_OVERFLOW;
        else
        begin
            stk_sym[k][stk_lvl[k]] = s;
            stk_lvl[k]++;
        end
    endfunction

    // closer against the top: pop on match, else missing or wrong opener
    function automatic void close_sym(input int k, input bbc_pkg::sym_t t,
                                      input bbc_pkg::sym_t s,
                                      input bbc_pkg::err_t missing,
                                      input bbc_pkg::err_t wrong);
        if (t == s)
            stk_lvl[k]--;
        else if (stk_lvl[k] == 0)
            first_err[k] = missing;
        else
            first_err[k] = wrong;
    endfunction

    function automatic void take_byte(input int k, input logic [7:0] c);
        bbc_pkg::sym_t t;
        bit            pend;
        bbc_pkg::sym_t s;
        t = top_sym(k);
        // inside a block comment only the star-slash pair matters
        if (in_cmt[k])
        begin
            if (cmt_star[k] && c == bbc_pkg::CH_SLASH)
            begin
                in_cmt[k]   = 1'b0;
                cmt_star[k] = 1'b0;
            end
            else
                cmt_star[k] = (c == bbc_pkg::CH_STAR);
            return;
        end
        if (line_cmt[k])
            return;
        pend = slash_wait[k];
        slash_wait[k] = 1'b0;
        // quote marks and backslash toggle against the top
        if (c == bbc_pkg::CH_APOS || c == bbc_pkg::CH_QUOTE || c == bbc_pkg::CH_BSLASH)
        begin
            s = (c == bbc_pkg::CH_APOS)  ? bbc_pkg::SYM_APOS :
                (c == bbc_pkg::CH_QUOTE) ? bbc_pkg::SYM_QUOTE : bbc_pkg::SYM_BSLASH;
            if (t == s || t == bbc_pkg::SYM_BSLASH)
                stk_lvl[k]--;
            else
                push_sym(k, s);
            return;
        end
        // escaped byte consumes the backslash
        if (t == bbc_pkg::SYM_BSLASH)
        begin
            stk_lvl[k]--;
            return;
        end
        if (t == bbc_pkg::SYM_APOS || t == bbc_pkg::SYM_QUOTE)
            return;
        case (c)
            bbc_pkg::CH_SLASH:
                if (pend)
                    line_cmt[k] = 1'b1;
                else
                    slash_wait[k] = 1'b1;
            bbc_pkg::CH_STAR:
                if (pend)
                begin
                    in_cmt[k]   = 1'b1;
                    cmt_star[k] = 1'b0;
                end
            bbc_pkg::CH_LBRACE:  push_sym(k, bbc_pkg::SYM_BRACE);
            bbc_pkg::CH_LPAREN:  push_sym(k, bbc_pkg::SYM_PAREN);
            bbc_pkg::CH_LSQUARE: push_sym(k, bbc_pkg::SYM_SQUARE);
            bbc_pkg::CH_RBRACE:
                close_sym(k, t, bbc_pkg::SYM_BRACE, bbc_pkg::ERR_MISS_BRACE,
                          bbc_pkg::ERR_WRONG_BRACE);
            bbc_pkg::CH_RPAREN:
                close_sym(k, t, bbc_pkg::SYM_PAREN, bbc_pkg::ERR_MISS_PAREN,
                          bbc_pkg::ERR_WRONG_PAREN);
            bbc_pkg::CH_RSQUARE:
                close_sym(k, t, bbc_pkg::SYM_SQUARE, bbc_pkg::ERR_MISS_SQUARE,
                          bbc_pkg::ERR_WRONG_SQUARE);
            default: ;
        endcase
    endfunction

    // one text word through the scanner, returns the status word it causes
    function automatic bbc_pkg::out_t scan_word(input int k, input bbc_pkg::in_t w);
        bbc_pkg::out_t r;
        bbc_pkg::sym_t t;
        if (first_err[k] == bbc_pkg::ERR_NONE)
        begin
            if (w.end_of_text)
            begin
                if (stk_lvl[k] != 0)
                    first_err[k] = bbc_pkg::ERR_UNCLOSED;
            end
            else
            begin
                take_byte(k, w.char_byte);
                if (first_err[k] == bbc_pkg::ERR_NONE && w.char_byte == bbc_pkg::CH_LF)
                begin
                    line_cmt[k] = 1'b0;
                    if (line_cnt[k] != bbc_pkg::LINE_MAX)
                        line_cnt[k]++;
                end
            end
        end
        t = top_sym(k);
        r.fault_code  = first_err[k];
        r.line_number = line_cnt[k];
        case (t)
            bbc_pkg::SYM_BRACE:  r.expected_close = bbc_pkg::CLOSE_BRACE;
            bbc_pkg::SYM_PAREN:  r.expected_close = bbc_pkg::CLOSE_PAREN;
            bbc_pkg::SYM_SQUARE: r.expected_close = bbc_pkg::CLOSE_SQUARE;
            default:             r.expected_close = bbc_pkg::CLOSE_NONE;
        endcase
        r.halted = (first_err[k] != bbc_pkg::ERR_NONE);
        return r;
    endfunction

    // queue a word; unless an error is wanted, refuse words that would set one
    function automatic bit queue_word(input bbc_pkg::in_t w, input bit may_fail);
        int unsigned   l;
        bit            b, s, p, q;
        logic [15:0]   n;
        bbc_pkg::err_t e;
        l = stk_lvl[PLAN];
        b = in_cmt[PLAN];
        s = cmt_star[PLAN];
        p = slash_wait[PLAN];
        q = line_cmt[PLAN];
        n = line_cnt[PLAN];
        e = first_err[PLAN];
        void'(scan_word(PLAN, w));
        if (!may_fail && first_err[PLAN] != bbc_pkg::ERR_NONE)
        begin
            stk_lvl[PLAN]    = l;
            in_cmt[PLAN]     = b;
            cmt_star[PLAN]   = s;
            slash_wait[PLAN] = p;
            line_cmt[PLAN]   = q;
            line_cnt[PLAN]   = n;
            first_err[PLAN]  = e;
            return 1'b0;
        end
        source_q.push_back(w);
        return 1'b1;
    endfunction

    function automatic void put_byte(input logic [7:0] c, input bit may_fail);
        bbc_pkg::in_t w;
        w.char_byte   = c;
        w.end_of_text = 1'b0;
        void'(queue_word(w, may_fail));
    endfunction

    function automatic void put_eot(input bit may_fail);
        bbc_pkg::in_t w;
        w.char_byte   = 8'($urandom_range(0, 255));
        w.end_of_text = 1'b1;
        void'(queue_word(w, may_fail));
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i], 1'b0);
    endfunction

    // byte that removes the top symbol
    function automatic logic [7:0] closer_for(input bbc_pkg::sym_t t);
        case (t)
            bbc_pkg::SYM_BRACE:  return bbc_pkg::CH_RBRACE;
            bbc_pkg::SYM_PAREN:  return bbc_pkg::CH_RPAREN;
            bbc_pkg::SYM_SQUARE: return bbc_pkg::CH_RSQUARE;
            bbc_pkg::SYM_APOS:   return bbc_pkg::CH_APOS;
            bbc_pkg::SYM_QUOTE:  return bbc_pkg::CH_QUOTE;
            default:             return "a";
        endcase
    endfunction

    // close comments, quotes and brackets until the planner is back at rest
    function automatic void drain_text();
        logic [7:0] c;
        while (stk_lvl[PLAN] != 0 || in_cmt[PLAN] || line_cmt[PLAN] || slash_wait[PLAN])
        begin
            if (in_cmt[PLAN])
                c = cmt_star[PLAN] ? bbc_pkg::CH_SLASH : bbc_pkg::CH_STAR;
            else if (line_cmt[PLAN])
                c = bbc_pkg::CH_LF;
            else
                c = closer_for(top_sym(PLAN));
            put_byte(c, 1'b0);
        end
    endfunction

    function automatic void fill_stack();
        for (int i = 0; i < bbc_pkg::STACK_DEPTH; i++)
            put_byte(OPEN_CH[$urandom_range(0, 2)], 1'b0);
    endfunction

    // source-like random word, weighted toward the symbols that matter
    function automatic bbc_pkg::in_t pick_word();
        bbc_pkg::in_t w;
        int           r;
        w.char_byte   = 8'($urandom_range(0, 255));
        w.end_of_text = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 25)
            w.char_byte = 8'($urandom_range(8'h20, 8'h7E));
        else if (r < 33)
            w.char_byte = bbc_pkg::CH_LF;
        else if (r < 45)
            w.char_byte = OPEN_CH[$urandom_range(0, 2)];
        else if (r < 60)
            w.char_byte = ($urandom_range(0, 3) != 0) ? closer_for(top_sym(PLAN))
                                                      : CLOSE_CH[$urandom_range(0, 2)];
        else if (r < 67)
            w.char_byte = $urandom_range(0, 1) ? bbc_pkg::CH_APOS : bbc_pkg::CH_QUOTE;
        else if (r < 72)
            w.char_byte = bbc_pkg::CH_BSLASH;
        else if (r < 79)
            w.char_byte = bbc_pkg::CH_SLASH;
        else if (r < 84)
            w.char_byte = bbc_pkg::CH_STAR;
        else if (r < 88)
            w.end_of_text = 1'b1;
        return w;
    endfunction

    function automatic void random_text(input int count);
        for (int i = 0; i < count; i++)
            while (!queue_word(pick_word(), 1'b0)) ;
    endfunction

    // idle length: mostly none or short, a few long, some calm stretches
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 150);
            return 0;
        end
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // text word driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_valid <= 1'b0;
            text_word  <= '0;
            tx_wait    <= 0;
        end
        else
        begin
            // word taken: predict its status
            if (text_valid && text_ready)
                report_q.push_back(scan_word(CHK, text_word));
            // next word or idle
            if (!text_valid || text_ready)
            begin
                if (tx_wait > 0)
                begin
                    text_valid <= 1'b0;
                    tx_wait    <= tx_wait - 1;
                end
                else if (source_q.size() != 0)
                begin
                    text_valid <= 1'b1;
                    text_word  <= source_q.pop_front();
                    tx_wait    <= idle_len(tx_calm);
                end
                else
                    text_valid <= 1'b0;
            end
        end
    end

    // status word monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            rx_wait      <= 0;
        end
        else
        begin
            rx_left = rx_wait;
            if (result_valid && result_ready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("status word with none expected");
                    fail_count++;
                end
                else
                begin
                    want = report_q.pop_front();
                    check_field("fault_code", 16'(want.fault_code),
                                16'(result_word.fault_code));
                    check_field("line_number", want.line_number, result_word.line_number);
                    check_field("expected_close", 16'(want.expected_close),
                                16'(result_word.expected_close));
                    check_field("halted", 16'(want.halted), 16'(result_word.halted));
                end
                rx_left = idle_len(rx_calm);
            end
            if (rx_left > 0)
            begin
                result_ready <= 1'b0;
                rx_wait      <= rx_left - 1;
            end
            else
            begin
                result_ready <= 1'b1;
                rx_wait      <= 0;
            end
        end
    end

    // stimulus plan, reset and end of run
    initial
    begin
        int kind;
        int a;
        clear_scan(CHK);
        clear_scan(PLAN);

        // directed: byte extremes, nesting, quotes with escape, comments,
        // end of text inside a block comment and with a slash pending
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_text("{([])}");
        put_text("\"(\\\"]\"");
        put_text("/*[");
        put_eot(1'b0);
        put_text("*/");
        put_text("/");
        put_eot(1'b0);
        put_text("//}\n");

        // random source with a nest that fills the stack exactly
        random_text(600);
        drain_text();
        fill_stack();
        drain_text();
        random_text(600);
        drain_text();
        random_text(50);

        // one error (unclosed, missing, wrong or overflow), then words that must be ignored
        drain_text();
        kind = $urandom_range(0, 3);
        a    = $urandom_range(0, 2);
        case (kind)
            0:
            begin
                if ($urandom_range(0, 3) == 0)
                    put_byte($urandom_range(0, 1) ? bbc_pkg::CH_APOS : bbc_pkg::CH_QUOTE,
                             1'b0);
                else
                    put_byte(OPEN_CH[a], 1'b0);
                put_eot(1'b1);
            end
            1:
                put_byte(CLOSE_CH[a], 1'b1);
            2:
            begin
                put_byte(OPEN_CH[a], 1'b0);
                put_byte(CLOSE_CH[(a + $urandom_range(1, 2)) % 3], 1'b1);
            end
            default:
            begin
                fill_stack();
                put_byte(OPEN_CH[a], 1'b1);
            end
        endcase
        for (int i = 0; i < 20; i++)
            void'(queue_word(pick_word(), 1'b1));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (source_q.size() != 0 || text_valid)
            @(posedge clk);
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // hang guard
    initial
    begin
        #400ms;
        $display("testbench failed");
        $finish;
    end

endmodule
